/* hdl/edet_pkg.sv */
package edet_pkg;

    // lookup result codes
    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_RESTART = 2'd1;
    localparam logic [1:0] ST_NEW     = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] CFG_ESCALATION = 2'd1;
    localparam logic [1:0] CFG_MAX_COUNT  = 2'd2;

    // configuration reset values
    localparam logic [15:0] DEBOUNCE_RESET   = 16'd100;
    localparam logic [15:0] ESCALATION_RESET = 16'd5000;
    localparam logic [15:0] MAX_COUNT_RESET  = 16'd10;

    // milliseconds to nanoseconds
    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // one table slot as held in the slot memory
    typedef struct packed {
        logic [31:0] code;
        logic [31:0] source;
        logic [63:0] first_time;
        logic [63:0] last_time;
        logic [31:0] count;
    } entry_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_WRITE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_run;
        logic eval;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic scan_end;
    } dp_stat_t;

endpackage

/* hdl/edet_ctrl.sv */
module edet_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  edet_pkg::dp_stat_t stat,
    output edet_pkg::dp_cmd_t  cmd
);
    import edet_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (stat.match)
                begin
                    state_next = S_EVAL;
                end
                else if (stat.scan_end)
                begin
                    state_next = S_WRITE;
                end
            end
            S_EVAL:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            S_WRITE:
            begin
                cmd.commit = !out_valid_reg || !out_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // output valid flag: set on commit, dropped once taken
    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/edet_dp.sv */
module edet_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [31:0]        event_code,
    input  logic [31:0]        event_source,
    input  logic [63:0]        event_time_ns,
    input  edet_pkg::dp_cmd_t  cmd,
    output edet_pkg::dp_stat_t stat,
    output logic [1:0]         lookup_status,
    output logic [5:0]         slot_index,
    output logic [31:0]        repeat_count,
    output logic               escalate
);
    import edet_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // configuration
    logic [15:0] deb_ms_reg;
    logic [15:0] esc_ms_reg;
    logic [15:0] max_cnt_reg;
    logic [63:0] deb_ns_reg;
    logic [63:0] esc_ns_reg;
    logic [35:0] deb_prod;
    logic [35:0] esc_prod;

    // held input item
    logic [31:0] code_reg;
    logic [31:0] source_reg;
    logic [63:0] time_reg;

    // slot memory and scan
    entry_t          mem [TABLE_DEPTH];
    entry_t          rd_data_reg;
    logic [CW-1:0]   used_reg;
    logic [CW-1:0]   used_next;
    logic [CW-1:0]   rd_ptr_reg;
    logic [IW-1:0]   tag_reg;
    logic            rd_vld_reg;
    logic            scan_step;

    // matched slot
    entry_t          entry_reg;
    logic [IW-1:0]   hit_idx_reg;
    logic            found_reg;

    // evaluation
    logic            in_window_reg;
    logic [63:0]     diff_first_reg;

    // commit
    entry_t          wr_entry;
    logic [IW-1:0]   wr_idx;
    logic            wr_en;
    logic [1:0]      status_c;
    logic [63:0]     dfirst_c;
    logic [31:0]     idx_wide;
    logic            esc_c;

    // configuration writes, indexes beyond the list ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_ms_reg  <= DEBOUNCE_RESET;
            esc_ms_reg  <= ESCALATION_RESET;
            max_cnt_reg <= MAX_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   deb_ms_reg  <= cfg_data;
                CFG_ESCALATION: esc_ms_reg  <= cfg_data;
                CFG_MAX_COUNT:  max_cnt_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // windows in ns, registered
    assign deb_prod = 36'(deb_ms_reg) * 36'(NS_PER_MS);
    assign esc_prod = 36'(esc_ms_reg) * 36'(NS_PER_MS);

    always_ff @(posedge clk)
    begin
        deb_ns_reg <= 64'(deb_prod);
        esc_ns_reg <= 64'(esc_prod);
    end

    // input item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg   <= event_code;
            source_reg <= event_source;
            time_reg   <= event_time_ns;
        end
    end

    // scan: one read issued per cycle, compared in the cycle after
    assign scan_step     = cmd.scan_run && (rd_ptr_reg < used_reg);
    assign stat.match    = rd_vld_reg && (rd_data_reg.code == code_reg)
                           && (rd_data_reg.source == source_reg);
    assign stat.scan_end = !rd_vld_reg && (rd_ptr_reg == used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            used_reg   <= '0;
        end
        else
        begin
            used_reg <= used_next;
            priority if (cmd.scan_start)
            begin
                rd_ptr_reg <= '0;
                rd_vld_reg <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                rd_vld_reg <= scan_step;
                if (scan_step)
                begin
                    rd_ptr_reg <= rd_ptr_reg + ONE_C;
                end
                if (stat.match)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (scan_step)
        begin
            rd_data_reg <= mem[rd_ptr_reg[IW-1:0]];
            tag_reg     <= rd_ptr_reg[IW-1:0];
        end
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
    end

    // matched slot capture and time differences
    always_ff @(posedge clk)
    begin
        if (cmd.scan_run && stat.match)
        begin
            entry_reg   <= rd_data_reg;
            hit_idx_reg <= tag_reg;
        end
        if (cmd.eval)
        begin
            in_window_reg  <= (time_reg - entry_reg.last_time) < deb_ns_reg;
            diff_first_reg <= time_reg - entry_reg.first_time;
        end
    end

    // updated slot, status and index
    always_comb
    begin
        wr_entry.code       = code_reg;
        wr_entry.source     = source_reg;
        wr_entry.first_time = time_reg;
        wr_entry.last_time  = time_reg;
        wr_entry.count      = 32'd1;
        wr_idx              = used_reg[IW-1:0];
        dfirst_c            = '0;
        used_next           = used_reg;
        priority if (found_reg)
        begin
            wr_idx = hit_idx_reg;
            if (in_window_reg)
            begin
                wr_entry.first_time = entry_reg.first_time;
                wr_entry.count      = (entry_reg.count == COUNT_MAX) ?
                                      entry_reg.count : entry_reg.count + 32'd1;
                dfirst_c            = diff_first_reg;
                status_c            = ST_HIT;
            end
            else
            begin
                status_c = ST_RESTART;
            end
        end
        else if (used_reg < DEPTH_C)
        begin
            status_c = ST_NEW;
            if (cmd.commit)
            begin
                used_next = used_reg + ONE_C;
            end
        end
        else
        begin
            status_c = ST_FULL;
            wr_idx   = '0;
        end
    end

    assign wr_en    = cmd.commit && (status_c != ST_FULL);
    assign esc_c    = (status_c != ST_FULL) && (dfirst_c < esc_ns_reg)
                      && (wr_entry.count >= 32'(max_cnt_reg));
    assign idx_wide = 32'(wr_idx);

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            lookup_status <= status_c;
            slot_index    <= idx_wide[5:0];
            repeat_count  <= wr_entry.count;
            escalate      <= esc_c;
        end
    end

endmodule

/* hdl/event_debounce_escalation_table.sv */
// Error event debounce and escalation table. Each item (event_code, event_source,
// event_time_ns) is looked up by a linear scan of the slots in use, one slot memory
// read per cycle, then the slot is updated or appended (nothing is written when the
// table is full) and one result item is produced. A match passes the scan, evaluate
// and write states; a miss goes from the scan straight to the write state. The input
// is free again the cycle after the result is loaded; the block takes one item at a
// time. The slot memory needs no clearing after reset: a fill count bounds the scan.
// A new item is taken while the previous result still waits on out_stall.
// Configuration registers: 0 debounce window (ms), 1 escalation window (ms), 2
// escalation count limit; write them only while the block is idle.
module event_debounce_escalation_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] event_code,
    input  logic [31:0] event_source,
    input  logic [63:0] event_time_ns,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  lookup_status,
    output logic [5:0]  slot_index,
    output logic [31:0] repeat_count,
    output logic        escalate
);
    import edet_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    edet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // slot table and arithmetic
    edet_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .event_code    (event_code),
        .event_source  (event_source),
        .event_time_ns (event_time_ns),
        .cmd           (cmd),
        .stat          (stat),
        .lookup_status (lookup_status),
        .slot_index    (slot_index),
        .repeat_count  (repeat_count),
        .escalate      (escalate)
    );

endmodule

/* hdl/edet_check.sv */
module edet_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  lookup_status,
    input logic [5:0]  slot_index,
    input logic [31:0] repeat_count,
    input logic        escalate
);
    import edet_pkg::*;

    logic [2:0] pending_reg;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            pending_reg <= pending_reg + 3'd1;
        end
        else if (out_take && !in_take)
        begin
            pending_reg <= pending_reg - 3'd1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lookup_status)
        && $stable(slot_index) && $stable(repeat_count) && $stable(escalate))
        else $error("stalled result changed");

    // no result without an accepted item
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> pending_reg != 3'd0)
        else $error("result without item");

    // one item at a time in the table
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("item accepted while busy");

    // full table result
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lookup_status == ST_FULL |->
        slot_index == 6'd0 && repeat_count == 32'd1 && !escalate)
        else $error("bad full result");

    // fresh slot starts counting at one
    a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (lookup_status == ST_NEW || lookup_status == ST_RESTART) |->
        repeat_count == 32'd1)
        else $error("fresh slot count not one");

endmodule

bind event_debounce_escalation_table edet_check u_check (.*);
